// ----- hdl/upd_pkg.sv -----
// Package for the URL percent decoder: character codes, word bundle type, hex helper.
`default_nettype none
package upd_pkg;

    localparam int QueueDepth = 4;    // default depth of the bundle queue
    localparam int MaxWords   = 3;    // words one input word can release

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChSpace   = 8'h20;

    // Escape state, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    // All output words caused by one input word.
    typedef struct packed {
        logic [MaxWords-1:0][7:0] words;
        logic [1:0]               cnt;    // 0..MaxWords
        logic                     last;   // bundle ends the string
    } t_bundle;

    // Front to queue write port.
    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_qwr;

    // Queue status seen by the back end.
    typedef struct packed {
        logic    empty;
        t_bundle head;
    } t_qrd;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/upd_stream_if.sv -----
// Stream interfaces for the decoder input and output channels.
`default_nettype none
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/upd_front.sv -----
// Front end: accepts input words, tracks escape state, builds output bundles.
`default_nettype none
module upd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    upd_in_if.sink             i_in,
    input  wire logic          i_q_full,
    output upd_pkg::t_qwr      o_wr
);

    upd_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_pend, n_pend;
    upd_pkg::t_bundle bnd;
    upd_pkg::t_hex    hc, hp;
    logic             do_plain;
    logic             acc;

    function automatic upd_pkg::t_bundle add_word(upd_pkg::t_bundle b, logic [7:0] w);
        upd_pkg::t_bundle r;
        r = b;
        if (b.cnt != 2'(upd_pkg::MaxWords)) begin
            r.words[b.cnt] = w;
            r.cnt          = b.cnt + 2'd1;
        end
        return r;
    endfunction

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && !i_q_full;

    always_comb begin
        hc       = upd_pkg::hex_decode(i_in.in_byte);
        hp       = upd_pkg::hex_decode(r_pend);
        n_phase  = r_phase;
        n_pend   = r_pend;
        bnd      = '0;
        do_plain = 1'b0;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (hc.ok) begin
                    n_phase = upd_pkg::PH_DIGIT;
                    n_pend  = i_in.in_byte;
                end else begin
                    bnd      = add_word(bnd, upd_pkg::ChPercent);
                    n_phase  = upd_pkg::PH_IDLE;
                    do_plain = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                n_phase = upd_pkg::PH_IDLE;
                n_pend  = 8'd0;
                if (hc.ok && hp.ok) begin
                    bnd = add_word(bnd, {hp.val, hc.val});
                end else begin
                    bnd      = add_word(bnd, upd_pkg::ChPercent);
                    bnd      = add_word(bnd, r_pend);
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_phase  = upd_pkg::PH_IDLE;
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            if (i_in.in_byte == upd_pkg::ChPercent) begin
                n_phase = upd_pkg::PH_PCT;
            end else if (i_in.in_byte == upd_pkg::ChPlus) begin
                bnd = add_word(bnd, upd_pkg::ChSpace);
            end else begin
                bnd = add_word(bnd, i_in.in_byte);
            end
        end

        // end of string: flush a dangling escape literally
        if (i_in.in_last) begin
            if (n_phase == upd_pkg::PH_PCT || n_phase == upd_pkg::PH_DIGIT) begin
                bnd = add_word(bnd, upd_pkg::ChPercent);
            end
            if (n_phase == upd_pkg::PH_DIGIT) begin
                bnd = add_word(bnd, n_pend);
            end
            n_phase = upd_pkg::PH_IDLE;
            n_pend  = 8'd0;
        end
        bnd.last = i_in.in_last;
    end

    assign o_wr.push   = acc && (bnd.cnt != 2'd0);
    assign o_wr.bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_pend  <= 8'd0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |=> (r_phase == upd_pkg::PH_IDLE))
        else $error("escape state survives end of string");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |-> o_wr.push)
        else $error("final word produced no output");

endmodule
`default_nettype wire

// ----- hdl/upd_queue.sv -----
// Small FIFO of output bundles between front and back end.
`default_nettype none
module upd_queue #(
    parameter int DEPTH = upd_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire upd_pkg::t_qwr i_wr,
    input  wire logic          i_pop,
    output upd_pkg::t_qrd      o_rd,
    output logic               o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_rd.empty = (r_count == '0);
    assign o_rd.head  = r_mem[r_rptr];
    assign do_push    = i_wr.push && !o_full;
    assign do_pop     = i_pop && !o_rd.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= ptr_inc(r_wptr);
            if (do_pop)  r_rptr <= ptr_inc(r_rptr);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("bundle pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_rd.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hdl/upd_back.sv -----
// Back end: unpacks queued bundles into single words behind an output register.
`default_nettype none
module upd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire upd_pkg::t_qrd i_rd,
    output logic               o_pop,
    upd_out_if.source          o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign load   = !i_rd.empty && (!r_valid || o_out.ready);
    assign at_end = (r_idx == i_rd.head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rd.head.words[r_idx];
            r_last <= i_rd.head.last && at_end;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rd.empty |-> (r_idx < i_rd.head.cnt))
        else $error("word index past end of bundle");

endmodule
`default_nettype wire

// ----- hdl/url_percent_decoder.sv -----
// Top level of the URL percent decoder.
// Decodes an URL string given one byte per word, in_last marking its final byte:
// "%hh" (either case) becomes one byte, '+' becomes a space, all else passes
// through; a broken or unterminated escape is output literally, and the last
// output word of each string carries out_last. A zero byte is ordinary data.
// A word is taken every cycle while the bundle queue has room; each input word
// is stored as a bundle of up to three output words, which the back end sends at
// one word per cycle through its output register while the output is ready.
// Since a string never yields more bytes than it had, the sustained rate is one
// word per cycle on both sides while the output is ready; a burst of three-word
// bundles is absorbed by the queue (QUEUE_DEPTH bundles). A decoded word passes
// through the queue memory and the back end's output register. No clearing pass after reset.
`default_nettype none
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    upd_in_if.sink    i_in,
    upd_out_if.source o_out
);

    upd_pkg::t_qwr wr;     // front -> queue
    upd_pkg::t_qrd rd;     // queue -> back
    logic          q_full;
    logic          pop;

    // escape tracking and bundle build
    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_wr     (wr)
    );

    // decouples the two sides
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_rd    (rd),
        .o_full  (q_full)
    );

    // word-at-a-time output
    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
